// ===== rtl/core/two_way_lru_cache_tag_model_defines.svh =====
// Assertion macros for the two-way LRU cache tag model.
// Expects clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef TWO_WAY_LRU_CACHE_TAG_MODEL_DEFINES_SVH
`define TWO_WAY_LRU_CACHE_TAG_MODEL_DEFINES_SVH

// Implication checked on the same edge.
`define TLC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on the next edge.
`define TLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tlc_pkg.sv =====
// Shared types and constants of the two-way LRU cache tag model.
// No dependencies; used by tlc_lookup and the top level.
package tlc_pkg;

  localparam int unsigned NUM_WAYS = 2;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_e;

  typedef struct packed {
    logic                hit;
    logic                evicted;
    logic                dirty_evicted;
    logic                way;
    logic                lru_next;
    logic [NUM_WAYS-1:0] fill;
    logic [NUM_WAYS-1:0] dirty_next;
  } lookup_t;

endpackage

// ===== rtl/core/tlc_set_ram.sv =====
// Per-set storage: one {dirty, tag} word per way and the LRU bit.
// Registered read, single write port; no dependencies.
module tlc_set_ram #(
  parameter int unsigned SET_BITS = 6,
  parameter int unsigned TAG_BITS = 36
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [SET_BITS-1:0] rd_set_i,
  output logic [TAG_BITS:0]   rd_word0_o,
  output logic [TAG_BITS:0]   rd_word1_o,
  output logic                rd_lru_o,
  input  logic                wr_en_i,
  input  logic [SET_BITS-1:0] wr_set_i,
  input  logic [TAG_BITS:0]   wr_word0_i,
  input  logic [TAG_BITS:0]   wr_word1_i,
  input  logic                wr_lru_i
);

  localparam int unsigned Depth = 2 ** SET_BITS;

  logic [TAG_BITS:0] way0_mem [Depth];
  logic [TAG_BITS:0] way1_mem [Depth];
  logic              lru_mem  [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      way0_mem[wr_set_i] <= wr_word0_i;
      way1_mem[wr_set_i] <= wr_word1_i;
      lru_mem[wr_set_i]  <= wr_lru_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_word0_o <= way0_mem[rd_set_i];
      rd_word1_o <= way1_mem[rd_set_i];
      rd_lru_o   <= lru_mem[rd_set_i];
    end
  end

endmodule

// ===== rtl/core/tlc_lookup.sv =====
// Tag compare, hit/miss decision and next set state for one access.
// Depends on tlc_pkg for the request code and the lookup result struct.
module tlc_lookup #(
  parameter int unsigned TAG_BITS = 36
) (
  input  tlc_pkg::req_e                  req_i,
  input  logic [TAG_BITS-1:0]            tag_i,
  input  logic [TAG_BITS-1:0]            tag0_i,
  input  logic [TAG_BITS-1:0]            tag1_i,
  input  logic [tlc_pkg::NUM_WAYS-1:0]   valid_i,
  input  logic [tlc_pkg::NUM_WAYS-1:0]   dirty_i,
  input  logic                           lru_i,
  output tlc_pkg::lookup_t               lookup_o
);

  logic [tlc_pkg::NUM_WAYS-1:0] match;
  logic [tlc_pkg::NUM_WAYS-1:0] dirty_eff;
  logic                         lru_eff;
  logic                         is_wr;
  tlc_pkg::lookup_t             res;

  always_comb begin
    match[0]  = valid_i[0] && (tag0_i == tag_i);
    match[1]  = valid_i[1] && (tag1_i == tag_i);
    dirty_eff = dirty_i & valid_i;
    // an untouched set reads as LRU 0, as the set RAM has no reset
    lru_eff   = lru_i & (|valid_i);
    is_wr     = (req_i == tlc_pkg::REQ_WRITE);
    res            = '0;
    res.dirty_next = dirty_eff;
    if (|match) begin
      res.hit                 = 1'b1;
      res.way                 = !match[0];
      res.dirty_next[res.way] = dirty_eff[res.way] | is_wr;
      res.lru_next            = (res.way == lru_eff) ? !lru_eff : lru_eff;
    end else begin
      res.way                 = lru_eff;
      res.evicted             = valid_i[lru_eff];
      res.dirty_evicted       = dirty_eff[lru_eff];
      res.dirty_next[lru_eff] = is_wr;
      res.fill[lru_eff]       = 1'b1;
      res.lru_next            = !lru_eff;
    end
    lookup_o = res;
  end

endmodule

// ===== rtl/core/two_way_lru_cache_tag_model.sv =====
// Two-way set-associative write-back cache tag model with one LRU bit per set.
// Path: set RAM read and input registers, then lookup into result registers.
// Throughput: one beat per cycle unless out_ready_i stalls the result; the set
// RAM's registered read is bypassed when back-to-back beats hit the same set.
// Reset clears valid bits and counters at once; no clearing pass is needed.
// Depends on tlc_pkg, tlc_set_ram, tlc_lookup and the assertion macro header.
`include "two_way_lru_cache_tag_model_defines.svh"

module two_way_lru_cache_tag_model #(
  parameter int unsigned SET_COUNT    = 64,
  parameter int unsigned LINE_BYTES   = 64,
  parameter int unsigned ADDR_BITS    = 48,
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    req_type_i,
  input  logic [ADDR_BITS-1:0]    address_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o,
  output logic                    evicted_o,
  output logic                    dirty_evicted_o,
  output logic                    victim_way_o,
  output logic [COUNTER_BITS-1:0] reads_total_o,
  output logic [COUNTER_BITS-1:0] writes_total_o,
  output logic [COUNTER_BITS-1:0] misses_total_o,
  output logic [COUNTER_BITS-1:0] evictions_total_o,
  output logic [COUNTER_BITS-1:0] dirty_evictions_total_o
);

  localparam int unsigned OffsetBits = $clog2(LINE_BYTES);
  localparam int unsigned SetBits    = $clog2(SET_COUNT);
  localparam int unsigned TagBits    = ADDR_BITS - OffsetBits - SetBits;
  localparam logic [COUNTER_BITS-1:0] CntOne = {{(COUNTER_BITS-1){1'b0}}, 1'b1};

  logic                  in_accept;
  logic                  adv;
  logic [SetBits-1:0]    in_set;
  logic [SetBits-1:0]    s1_set;
  logic [TagBits-1:0]    s1_tag;

  logic                  s1_valid_q;
  tlc_pkg::req_e         s1_req_q;
  logic [ADDR_BITS-1:0]  s1_addr_q;

  logic [TagBits:0]      rd_word0;
  logic [TagBits:0]      rd_word1;
  logic                  rd_lru;
  logic                  byp_q;
  logic [TagBits:0]      byp_word0_q;
  logic [TagBits:0]      byp_word1_q;
  logic                  byp_lru_q;
  logic [TagBits:0]      cur_word0;
  logic [TagBits:0]      cur_word1;
  logic                  cur_lru;
  logic [TagBits:0]      new_word0;
  logic [TagBits:0]      new_word1;

  logic [SET_COUNT-1:0]  valid0_q;
  logic [SET_COUNT-1:0]  valid1_q;

  tlc_pkg::lookup_t      lk;

  logic                  out_valid_q;
  logic                  hit_q;
  logic                  evicted_q;
  logic                  dirty_evicted_q;
  logic                  way_q;
  logic [COUNTER_BITS-1:0] rd_cnt_q;
  logic [COUNTER_BITS-1:0] wr_cnt_q;
  logic [COUNTER_BITS-1:0] miss_cnt_q;
  logic [COUNTER_BITS-1:0] ev_cnt_q;
  logic [COUNTER_BITS-1:0] dev_cnt_q;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_accept  = in_valid_i && in_ready_o;

  assign in_set = address_i[OffsetBits +: SetBits];
  assign s1_set = s1_addr_q[OffsetBits +: SetBits];
  assign s1_tag = s1_addr_q[ADDR_BITS-1 -: TagBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        byp_q      <= adv && (s1_set == in_set);
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q    <= tlc_pkg::req_e'(req_type_i);
      s1_addr_q   <= address_i;
      byp_word0_q <= new_word0;
      byp_word1_q <= new_word1;
      byp_lru_q   <= lk.lru_next;
    end
  end

  tlc_set_ram #(
    .SET_BITS (SetBits),
    .TAG_BITS (TagBits)
  ) u_set_ram (
    .clk_i      (clk_i),
    .rd_en_i    (in_accept),
    .rd_set_i   (in_set),
    .rd_word0_o (rd_word0),
    .rd_word1_o (rd_word1),
    .rd_lru_o   (rd_lru),
    .wr_en_i    (adv),
    .wr_set_i   (s1_set),
    .wr_word0_i (new_word0),
    .wr_word1_i (new_word1),
    .wr_lru_i   (lk.lru_next)
  );

  assign cur_word0 = byp_q ? byp_word0_q : rd_word0;
  assign cur_word1 = byp_q ? byp_word1_q : rd_word1;
  assign cur_lru   = byp_q ? byp_lru_q : rd_lru;

  tlc_lookup #(
    .TAG_BITS (TagBits)
  ) u_lookup (
    .req_i    (s1_req_q),
    .tag_i    (s1_tag),
    .tag0_i   (cur_word0[TagBits-1:0]),
    .tag1_i   (cur_word1[TagBits-1:0]),
    .valid_i  ({valid1_q[s1_set], valid0_q[s1_set]}),
    .dirty_i  ({cur_word1[TagBits], cur_word0[TagBits]}),
    .lru_i    (cur_lru),
    .lookup_o (lk)
  );

  assign new_word0 = {lk.dirty_next[0], lk.fill[0] ? s1_tag : cur_word0[TagBits-1:0]};
  assign new_word1 = {lk.dirty_next[1], lk.fill[1] ? s1_tag : cur_word1[TagBits-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q    <= '0;
      valid1_q    <= '0;
      out_valid_q <= 1'b0;
      rd_cnt_q    <= '0;
      wr_cnt_q    <= '0;
      miss_cnt_q  <= '0;
      ev_cnt_q    <= '0;
      dev_cnt_q   <= '0;
    end else begin
      if (adv) begin
        valid0_q[s1_set] <= valid0_q[s1_set] | lk.fill[0];
        valid1_q[s1_set] <= valid1_q[s1_set] | lk.fill[1];
        out_valid_q      <= 1'b1;
        if (s1_req_q == tlc_pkg::REQ_WRITE) begin
          wr_cnt_q <= wr_cnt_q + CntOne;
        end else begin
          rd_cnt_q <= rd_cnt_q + CntOne;
        end
        if (!lk.hit) begin
          miss_cnt_q <= miss_cnt_q + CntOne;
        end
        if (lk.evicted) begin
          ev_cnt_q <= ev_cnt_q + CntOne;
        end
        if (lk.dirty_evicted) begin
          dev_cnt_q <= dev_cnt_q + CntOne;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q           <= lk.hit;
      evicted_q       <= lk.evicted;
      dirty_evicted_q <= lk.dirty_evicted;
      way_q           <= lk.way;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign hit_o                   = hit_q;
  assign evicted_o               = evicted_q;
  assign dirty_evicted_o         = dirty_evicted_q;
  assign victim_way_o            = way_q;
  assign reads_total_o           = rd_cnt_q;
  assign writes_total_o          = wr_cnt_q;
  assign misses_total_o          = miss_cnt_q;
  assign evictions_total_o       = ev_cnt_q;
  assign dirty_evictions_total_o = dev_cnt_q;

  `TLC_ASSERT_IMP(a_hit_no_evict, out_valid_q && hit_q, !evicted_q && !dirty_evicted_q, "hit reported an eviction")
  `TLC_ASSERT_IMP(a_dirty_implies_evict, out_valid_q && dirty_evicted_q, evicted_q, "dirty eviction without eviction")
  `TLC_ASSERT_NEXT(a_miss_count, adv && !lk.hit, miss_cnt_q == ($past(miss_cnt_q) + CntOne), "miss counter did not advance")

endmodule

// ===== tb/two_way_lru_cache_tag_model_tb.sv =====
// Self-checking bench for the two-way LRU cache tag model: a tag, valid, dirty and LRU
// predictor scores every result beat, with random idling on both handshakes.
// Depends on tlc_pkg and the two_way_lru_cache_tag_model RTL.
module two_way_lru_cache_tag_model_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned OFF_W       = 6;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned TAG_W       = ADDR_W - OFF_W - IDX_W;
  localparam int unsigned SETS        = 64;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned CALM_TAIL   = 150;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    tlc_pkg::req_e     kind;
    logic [ADDR_W-1:0] addr;
  } access_t;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic             dirty_evicted;
    logic             way;
    logic [CNT_W-1:0] reads;
    logic [CNT_W-1:0] writes;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
    logic [CNT_W-1:0] dirty_evictions;
  } outcome_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              req_type_i = 1'b0;
  logic [ADDR_W-1:0] address_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              hit_o;
  logic              evicted_o;
  logic              dirty_evicted_o;
  logic              victim_way_o;
  logic [CNT_W-1:0]  reads_total_o;
  logic [CNT_W-1:0]  writes_total_o;
  logic [CNT_W-1:0]  misses_total_o;
  logic [CNT_W-1:0]  evictions_total_o;
  logic [CNT_W-1:0]  dirty_evictions_total_o;

  access_t  access_q[$];
  outcome_t outcome_q[$];

  logic [TAG_W-1:0] tag_mem    [SETS][2];
  logic             line_valid [SETS][2];
  logic             line_dirty [SETS][2];
  logic             lru        [SETS];
  logic [CNT_W-1:0] n_reads, n_writes, n_misses, n_evict, n_dirty_evict;

  logic [TAG_W-1:0] tag_pool [4];
  logic             in_fire = 1'b0;
  int unsigned      in_gap = 0;
  int unsigned      out_gap = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      errors = 0;

  two_way_lru_cache_tag_model #(
    .SET_COUNT    (SETS),
    .LINE_BYTES   (64),
    .ADDR_BITS    (ADDR_W),
    .COUNTER_BITS (CNT_W)
  ) dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_ready_o              (in_ready_o),
    .req_type_i              (req_type_i),
    .address_i               (address_i),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .hit_o                   (hit_o),
    .evicted_o               (evicted_o),
    .dirty_evicted_o         (dirty_evicted_o),
    .victim_way_o            (victim_way_o),
    .reads_total_o           (reads_total_o),
    .writes_total_o          (writes_total_o),
    .misses_total_o          (misses_total_o),
    .evictions_total_o       (evictions_total_o),
    .dirty_evictions_total_o (dirty_evictions_total_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic outcome_t cache_access(access_t a);
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
    logic             victim;
    outcome_t         o;
    idx    = a.addr[OFF_W +: IDX_W];
    tag    = a.addr[ADDR_W-1 -: TAG_W];
    victim = lru[idx];
    o      = '0;
    o.way  = victim;
    if (a.kind == tlc_pkg::REQ_WRITE) n_writes++;
    else n_reads++;
    for (int w = 0; w < 2; w++) begin
      if (!o.hit && line_valid[idx][w] && tag_mem[idx][w] == tag) begin
        o.hit = 1'b1;
        o.way = w[0];
      end
    end
    if (o.hit) begin
      if (a.kind == tlc_pkg::REQ_WRITE) line_dirty[idx][o.way] = 1'b1;
      if (o.way == victim) lru[idx] = ~victim;
    end else begin
      n_misses++;
      if (line_valid[idx][victim]) begin
        o.evicted = 1'b1;
        n_evict++;
        if (line_dirty[idx][victim]) begin
          o.dirty_evicted = 1'b1;
          n_dirty_evict++;
        end
      end
      tag_mem[idx][victim]    = tag;
      line_valid[idx][victim] = 1'b1;
      line_dirty[idx][victim] = (a.kind == tlc_pkg::REQ_WRITE);
      lru[idx]                = ~victim;
    end
    o.reads           = n_reads;
    o.writes          = n_writes;
    o.misses          = n_misses;
    o.evictions       = n_evict;
    o.dirty_evictions = n_dirty_evict;
    return o;
  endfunction

  function automatic access_t line_access(tlc_pkg::req_e k, logic [TAG_W-1:0] tag,
                                          logic [IDX_W-1:0] idx, logic [OFF_W-1:0] off);
    access_t a;
    a.kind = k;
    a.addr = {tag, idx, off};
    return a;
  endfunction

  task automatic push_random(int unsigned n);
    access_t          a;
    logic [IDX_W-1:0] last_idx;
    int unsigned      mode;
    last_idx = '0;
    for (int unsigned i = 0; i < n; i++) begin
      mode   = $urandom_range(0, 9);
      a.kind = tlc_pkg::req_e'($urandom_range(0, 1));
      if (mode <= 6) begin
        a.addr = {tag_pool[$urandom_range(0, 3)], IDX_W'($urandom_range(0, SETS - 1)),
                  OFF_W'($urandom)};
      end else if (mode == 7) begin
        a.addr = {tag_pool[$urandom_range(0, 3)], last_idx, OFF_W'($urandom)};
      end else begin
        a.addr = {16'($urandom), 32'($urandom)};
      end
      last_idx = a.addr[OFF_W +: IDX_W];
      access_q.push_back(a);
    end
  endtask

  task automatic drain();
    while (access_q.size() != 0 || in_valid_i || outcome_q.size() != 0) @(negedge clk_i);
  endtask

  // Hold each beat until it is taken, then insert an idle burst now and then.
  always @(negedge clk_i) begin : driver
    access_t nxt;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      if (!in_valid_i || in_fire) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap = in_gap - 1;
        end else if (access_q.size() != 0) begin
          nxt = access_q.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= nxt.kind;
          address_i  <= nxt.addr;
          if (access_q.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
            in_gap = $urandom_range(1, 7);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_ready_i <= 1'b0;
        out_gap = out_gap - 1;
      end else begin
        out_ready_i <= 1'b1;
        if (access_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
          out_gap = $urandom_range(1, 7);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    access_t  seen;
    outcome_t got;
    outcome_t want;
    in_fire <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        seen.kind = tlc_pkg::req_e'(req_type_i);
        seen.addr = address_i;
        outcome_q.push_back(cache_access(seen));
      end
      if (out_valid_o && out_ready_i) begin
        got = '{hit_o, evicted_o, dirty_evicted_o, victim_way_o, reads_total_o,
                writes_total_o, misses_total_o, evictions_total_o, dirty_evictions_total_o};
        if (outcome_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("result beat with nothing pending: %p", got);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < SETS; s++) begin
      lru[s] = 1'b0;
      for (int w = 0; w < 2; w++) begin
        tag_mem[s][w]    = '0;
        line_valid[s][w] = 1'b0;
        line_dirty[s][w] = 1'b0;
      end
    end
    n_reads       = '0;
    n_writes      = '0;
    n_misses      = '0;
    n_evict       = '0;
    n_dirty_evict = '0;
    for (int k = 0; k < 4; k++) tag_pool[k] = {4'($urandom_range(0, 15)), 32'($urandom)};

    // Cold miss, hits, dirty and clean evictions, extremes and same-set beats.
    access_q.push_back(line_access(tlc_pkg::REQ_READ,  '0, '0, '0));
    access_q.push_back(line_access(tlc_pkg::REQ_READ,  '0, '0, '1));
    access_q.push_back(line_access(tlc_pkg::REQ_WRITE, '0, '0, 6'd17));
    access_q.push_back(line_access(tlc_pkg::REQ_READ,  36'd1, '0, '0));
    access_q.push_back(line_access(tlc_pkg::REQ_READ,  36'd2, '0, '0));
    access_q.push_back(line_access(tlc_pkg::REQ_READ,  36'd3, '0, '0));
    access_q.push_back(line_access(tlc_pkg::REQ_WRITE, '1, '1, '1));
    access_q.push_back(line_access(tlc_pkg::REQ_READ,  '1, '1, '0));
    access_q.push_back(line_access(tlc_pkg::REQ_READ,  '0, '1, '0));
    access_q.push_back(line_access(tlc_pkg::REQ_WRITE, '0, '1, '1));
    access_q.push_back(line_access(tlc_pkg::REQ_READ,  36'd5, '1, '0));
    access_q.push_back(line_access(tlc_pkg::REQ_WRITE, 36'hA_AAAA_AAAA, 6'h2A, 6'h2A));
    access_q.push_back(line_access(tlc_pkg::REQ_WRITE, 36'h5_5555_5555, 6'h2A, 6'h15));
    access_q.push_back(line_access(tlc_pkg::REQ_READ,  36'hA_AAAA_AAAA, 6'h2A, '0));
    access_q.push_back(line_access(tlc_pkg::REQ_READ,  36'h1_2345_6789, 6'h2A, '0));
    access_q.push_back(line_access(tlc_pkg::REQ_READ,  36'h5_5555_5555, 6'h2A, '0));
    access_q.push_back(line_access(tlc_pkg::REQ_WRITE, 36'h5_5555_5555, 6'h2A, '1));
    access_q.push_back(line_access(tlc_pkg::REQ_READ,  36'hA_AAAA_AAAA, 6'h2A, '0));
    access_q.push_back(line_access(tlc_pkg::REQ_WRITE, 36'h5_5555_5555, 6'h15, '0));
    access_q.push_back(line_access(tlc_pkg::REQ_READ,  36'hA_AAAA_AAAA, 6'h15, '0));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    drain();
    push_random(550);
    drain();
    push_random(550);
    drain();
    repeat (20) @(posedge clk_i);

    if (errors == 0 && outcome_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
